// ===== src/tt_pkg.sv =====
// Package for the text terminal writer: screen geometry, character codes,
// cell helpers and the command/status types shared by controller and datapath.
// No dependencies.
package tt_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int PTR_W   = $clog2(CELLS + 1);

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = CHAR_W + ATTR_W;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_SET   = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_DELETE    = 8'd127;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  // What the latched request asks for.
  typedef enum logic [2:0] {
    K_PRINT,
    K_NEWLINE,
    K_BACKSPACE,
    K_DELETE,
    K_READ,
    K_READ_NONE,
    K_SET,
    K_CLEAR
  } kind_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_INIT_FILL,
    S_IDLE,
    S_EXEC,
    S_READ_WAIT,
    S_MOVE_RD,
    S_MOVE_WR,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic rd_capture;
    logic move_rd;
    logic move_wr;
    logic fill_wr;
    logic init_setup;
    logic load_out;
  } tt_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  scroll_needed;
    logic  move_done;
    logic  fill_done;
    logic  out_free;
  } tt_status_t;

  function automatic logic [PTR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    cell_addr = PTR_W'(PTR_W'(r) * PTR_W'(COLUMNS)) + PTR_W'(c);
  endfunction

endpackage

// ===== src/tt_ctrl.sv =====
// Controller state machine of the text terminal writer.
// Depends on tt_pkg; drives the datapath through tt_cmd_t and reads tt_status_t.
module tt_ctrl
  import tt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  tt_status_t status,
  output tt_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.init_setup = 1'b1;
        state_next     = S_INIT_FILL;
      end
      S_INIT_FILL: begin
        if (status.fill_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.fill_wr = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (status.kind) inside
          K_READ: state_next = S_READ_WAIT;
          K_DELETE, K_CLEAR: state_next = S_MOVE_RD;
          K_PRINT, K_NEWLINE: state_next = status.scroll_needed ? S_MOVE_RD : S_DONE;
          default: state_next = S_DONE;
        endcase
      end
      S_READ_WAIT: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_DONE;
      end
      S_MOVE_RD: begin
        if (status.move_done) begin
          state_next = S_FILL;
        end else begin
          cmd.move_rd = 1'b1;
          state_next  = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_next  = S_MOVE_RD;
      end
      S_FILL: begin
        if (status.fill_done) begin
          state_next = S_DONE;
        end else begin
          cmd.fill_wr = 1'b1;
        end
      end
      S_DONE: begin
        // Wait until the output register is free or being emptied.
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

// ===== src/tt_datapath.sv =====
// Datapath of the text terminal writer: screen memory, cursor, block pointers
// and the result register. Depends on tt_pkg; commanded by tt_ctrl.
module tt_datapath
  import tt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  tt_cmd_t           cmd,
  output tt_status_t        status,
  input  logic [1:0]        in_mode,
  input  logic [CHAR_W-1:0] in_char,
  input  logic [COL_W-1:0]  in_col,
  input  logic [ROW_W-1:0]  in_row,
  input  logic              attr_wen,
  input  logic [ATTR_W-1:0] attr_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_data
);

  logic [CELL_W-1:0] screen [CELLS];
  logic [CELL_W-1:0] rdata;

  logic [1:0]        item_mode;
  logic [CHAR_W-1:0] item_char;
  logic [COL_W-1:0]  item_col;
  logic [ROW_W-1:0]  item_row;

  logic [ATTR_W-1:0] attr;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;

  logic [PTR_W-1:0]  dst, offset, move_end, fill_end;
  logic [CELL_W-1:0] fill_val;

  logic [CHAR_W-1:0] res_char, res_attr;
  logic              res_beep;

  kind_t             kind;
  logic              in_range, at_home, wrap_line;
  logic [PTR_W-1:0]  cur_addr, row_base, item_addr;
  logic [CELL_W-1:0] blank;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data;

  assign blank     = {attr, CH_SPACE};
  assign cur_addr  = cell_addr(cur_row, cur_col);
  assign row_base  = cell_addr(cur_row, '0);
  assign item_addr = cell_addr(item_row, item_col);
  assign in_range  = ({1'b0, item_col} < (COL_W + 1)'(COLUMNS)) &&
                     ({1'b0, item_row} < (ROW_W + 1)'(ROWS));
  assign at_home   = (cur_col == '0) && (cur_row == '0);

  always_comb begin
    kind = K_PRINT;
    unique case (item_mode)
      MODE_PUT: begin
        if (item_char == CH_NEWLINE) kind = K_NEWLINE;
        else if (item_char == CH_BACKSPACE) kind = K_BACKSPACE;
        else if (item_char == CH_DELETE) kind = K_DELETE;
        else kind = K_PRINT;
      end
      MODE_READ:  kind = in_range ? K_READ : K_READ_NONE;
      MODE_SET:   kind = K_SET;
      MODE_CLEAR: kind = K_CLEAR;
      default:    kind = K_PRINT;
    endcase
  end

  // A printed character in the last column wraps the same way a newline does.
  assign wrap_line = (kind == K_NEWLINE) || ((kind == K_PRINT) && (cur_col == COL_LAST));

  assign status.kind          = kind;
  assign status.scroll_needed = wrap_line && (cur_row == ROW_LAST);
  assign status.move_done     = (dst >= move_end);
  assign status.fill_done     = (dst >= fill_end);
  assign status.out_free      = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode <= in_mode;
      item_char <= in_char;
      item_col  <= in_col;
      item_row  <= in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (attr_wen) begin
      attr <= attr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.exec) begin
      case (kind) inside
        K_PRINT, K_NEWLINE: begin
          if (wrap_line) begin
            cur_col <= '0;
            if (cur_row != ROW_LAST) cur_row <= cur_row + 1'b1;
          end else begin
            cur_col <= cur_col + 1'b1;
          end
        end
        K_BACKSPACE: begin
          if (cur_col != '0) begin
            cur_col <= cur_col - 1'b1;
          end else if (cur_row != '0) begin
            cur_row <= cur_row - 1'b1;
            cur_col <= COL_LAST;
          end
        end
        K_SET: begin
          cur_col <= ({1'b0, item_col} < (COL_W + 1)'(COLUMNS)) ? item_col : COL_LAST;
          cur_row <= ({1'b0, item_row} < (ROW_W + 1)'(ROWS)) ? item_row : ROW_LAST;
        end
        K_CLEAR: begin
          cur_col <= '0;
          cur_row <= '0;
        end
        default: ;
      endcase
    end
  end

  // Block pointers: a move copies dst+offset to dst up to move_end, then the
  // fill blanks the cells from there up to fill_end.
  always_ff @(posedge clk) begin
    if (cmd.init_setup) begin
      dst      <= '0;
      offset   <= '0;
      move_end <= '0;
      fill_end <= PTR_W'(CELLS);
      fill_val <= CELL_RESET;
    end else if (cmd.exec) begin
      fill_val <= blank;
      if (kind == K_DELETE) begin
        dst      <= cur_addr;
        offset   <= PTR_W'(1);
        move_end <= row_base + PTR_W'(COLUMNS - 1);
        fill_end <= row_base + PTR_W'(COLUMNS);
      end else if (kind == K_CLEAR) begin
        dst      <= '0;
        offset   <= '0;
        move_end <= '0;
        fill_end <= PTR_W'(CELLS);
      end else begin
        dst      <= '0;
        offset   <= PTR_W'(COLUMNS);
        move_end <= PTR_W'((ROWS - 1) * COLUMNS);
        fill_end <= PTR_W'(CELLS);
      end
    end else if (cmd.move_wr || cmd.fill_wr) begin
      dst <= dst + 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dst[ADDR_W-1:0];
    wr_data = fill_val;
    if (cmd.exec && (kind == K_PRINT)) begin
      wr_en   = 1'b1;
      wr_addr = cur_addr[ADDR_W-1:0];
      wr_data = {attr, item_char};
    end else if (cmd.exec && (kind == K_BACKSPACE) && !at_home) begin
      // The cell one step back is always the previous linear address.
      wr_en   = 1'b1;
      wr_addr = ADDR_W'(cur_addr - 1'b1);
      wr_data = blank;
    end else if (cmd.move_wr) begin
      wr_en   = 1'b1;
      wr_data = rdata;
    end else if (cmd.fill_wr) begin
      wr_en   = 1'b1;
    end
  end

  assign rd_en   = cmd.move_rd || (cmd.exec && (kind == K_READ));
  assign rd_addr = cmd.move_rd ? ADDR_W'(dst + offset) : item_addr[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      screen[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= screen[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_char <= '0;
      res_attr <= '0;
      res_beep <= (kind == K_BACKSPACE) && at_home;
    end else if (cmd.rd_capture) begin
      res_char <= rdata[CHAR_W-1:0];
      res_attr <= rdata[CELL_W-1:CHAR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {3'b000, res_beep, cur_row, cur_col, res_attr, res_char};
    end
  end

endmodule

// ===== src/text_terminal_writer_top.sv =====
// Top level of the text terminal writer: a character-cell screen with a cursor.
// Depends on tt_pkg, tt_ctrl and tt_datapath.
//
// Requests come in on the s_axis channel, one result per request leaves on
// m_axis. The attribute register is written with attr_wen/attr_wdata; the
// user must write it only while the block is idle, which the block itself
// does not enforce. It colors every cell that a request writes or blanks.
// From acceptance to the result being offered, a request passes the exec
// state and ends in the done state; a read of a cell inside the screen also
// waits for the memory read. Delete shifts the rest of the cursor row left
// and blanks the row's last cell; clear screen blanks every cell (one blank
// cell written a cycle); a scroll (newline or wrap on the last row) moves
// rows 1 to ROWS - 1 up one row and blanks the last row, each moved cell
// taking a read state and then a write state.
// After reset the block blanks all COLUMNS * ROWS cells, one a cycle, before
// s_axis_tready rises.
// A result sits in an output register; the next request is taken while it
// waits, and the block holds its finished result when the receiver stalls.
module text_terminal_writer_top
  import tt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata fields from bit 0: char_code[7:0], col[14:8], row[19:15], zero fill.
  input  logic [23:0] s_axis_tdata,
  // tuser fields from bit 0: mode[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata fields from bit 0: cell_char[7:0], cell_attr[15:8], cursor_col[22:16],
  // cursor_row[27:23], beep[28], zero fill.
  output logic [31:0] m_axis_tdata,
  input  logic        attr_wen,
  input  logic [7:0]  attr_wdata
);

  tt_cmd_t    cmd;
  tt_status_t status;

  tt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tt_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_mode    (s_axis_tuser),
    .in_char    (s_axis_tdata[7:0]),
    .in_col     (s_axis_tdata[14:8]),
    .in_row     (s_axis_tdata[19:15]),
    .attr_wen   (attr_wen),
    .attr_wdata (attr_wdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

endmodule

// ===== src/tt_checker.sv =====
// Port-level checks for the text terminal writer, bound to its top level.
// Depends on tt_pkg and text_terminal_writer_top.
module tt_checker
  import tt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) $past(rst) && !rst |-> !m_axis_tvalid)
    else $error("result offered right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // A request is worked on before the next is taken: s_axis_tready is low in the cycle after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in work");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[22:16]} < (COL_W + 1)'(COLUMNS)) &&
                      ({1'b0, m_axis_tdata[27:23]} < (ROW_W + 1)'(ROWS)))
    else $error("cursor outside the screen");

  // A beep only comes from a backspace at home, which leaves the cursor there.
  a_beep_home: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[28] |->
      (m_axis_tdata[27:16] == '0) && (m_axis_tdata[15:0] == '0))
    else $error("beep away from the home position");

endmodule

bind text_terminal_writer_top tt_checker u_tt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
